// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros used by the acm_checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge out of reset
`define ACM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define ACM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/acm_pkg.sv -----
// ----------------------------------------------------------------------------
// acm_pkg
// Types, constants and the reciprocal table of the audio channel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int NARROW_W    = 8;
  localparam int LANES_DEF   = 8;
  localparam int LANES_MAX   = 16;
  localparam int CNT_OUT_W   = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int MAX_CH_W    = 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 24;
  localparam int RECIP_IDX_W = $clog2(LANES_MAX + 1);

  localparam logic [MAX_CH_W-1:0] MAX_CH_RESET = MAX_CH_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE,
    REG_SAMPLE_WIDTH,
    REG_LANE_LIMIT,
    REG_SELECT_OLDEST
  } acm_reg_t;

  typedef enum logic {
    MIX_FAST,
    MIX_QUALITY
  } acm_mix_t;

  typedef enum logic {
    WIDTH_8,
    WIDTH_16
  } acm_width_t;

  // per-frame control that travels with the data
  typedef struct packed {
    acm_mix_t   mode;
    acm_width_t width;
    logic       last;
  } acm_ctl_t;

  // load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } acm_en_t;

  // ceil(2^24 / d); exact truncating quotient for dividends below 2^20
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [RECIP_IDX_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      RECIP_IDX_W'(2):  r = RECIP_W'(8388608);
      RECIP_IDX_W'(3):  r = RECIP_W'(5592406);
      RECIP_IDX_W'(4):  r = RECIP_W'(4194304);
      RECIP_IDX_W'(5):  r = RECIP_W'(3355444);
      RECIP_IDX_W'(6):  r = RECIP_W'(2796203);
      RECIP_IDX_W'(7):  r = RECIP_W'(2396746);
      RECIP_IDX_W'(8):  r = RECIP_W'(2097152);
      RECIP_IDX_W'(9):  r = RECIP_W'(1864136);
      RECIP_IDX_W'(10): r = RECIP_W'(1677722);
      RECIP_IDX_W'(11): r = RECIP_W'(1525202);
      RECIP_IDX_W'(12): r = RECIP_W'(1398102);
      RECIP_IDX_W'(13): r = RECIP_W'(1290556);
      RECIP_IDX_W'(14): r = RECIP_W'(1198373);
      RECIP_IDX_W'(15): r = RECIP_W'(1118482);
      RECIP_IDX_W'(16): r = RECIP_W'(1048576);
      // zero and one lane bypass the divider
      default:          r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/acm_ifs.sv -----
// ----------------------------------------------------------------------------
// acm channel interfaces
// Frame input, mixed sample output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface acm_in_if #(
  parameter int LANES = acm_pkg::LANES_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic [LANES-1:0][acm_pkg::SAMPLE_W-1:0] sample_lane;
  logic [LANES-1:0]                      active_mask;
  logic                                  last_in_buffer;

  modport source (output valid, output sample_lane, output active_mask,
                  output last_in_buffer, input ready);
  modport sink   (input valid, input sample_lane, input active_mask,
                  input last_in_buffer, output ready);
endinterface

interface acm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [acm_pkg::SAMPLE_W-1:0]  mixed_sample;
  logic [acm_pkg::CNT_OUT_W-1:0]        lanes_mixed;
  logic                                 end_of_buffer;

  modport source (output valid, output mixed_sample, output lanes_mixed,
                  output end_of_buffer, input ready);
  modport sink   (input valid, input mixed_sample, input lanes_mixed,
                  input end_of_buffer, output ready);
endinterface

interface acm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [acm_pkg::CFG_IDX_W-1:0]    index;
  logic [acm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/audio_channel_mixer.sv -----
// ----------------------------------------------------------------------------
// audio_channel_mixer
// Mixes one frame of up to LANES playback lanes into one output sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   frame transactions: LANES samples, active mask, last-of-buffer
//   out_if  one mixed sample per frame, with lane count and end-of-buffer
//   cfg_if  register writes (mode, width, channel limit, selection order),
//           always ready; write only while no frame is in flight
// Pipeline: a frame accepted on in_if passes four register stages (lane
//   select, lane multiply, quotient/wide multiply, result) on its way to
//   out_if.
// Throughput: one frame per cycle while out_if is ready. Each lane has its own reciprocal
//   multiplier, and the quality path uses one shared multiplier on the sum.
// Reset: rst_n low clears the pipeline and restores fast mode, 16-bit
//   samples, a limit of four lanes and youngest-first selection.
// Stall: while out_if is not ready the result holds; earlier stages keep
//   filling until every stage holds a frame, then in_if.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_channel_mixer #(
  parameter int LANES = acm_pkg::LANES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  acm_in_if.sink     in_if,
  acm_out_if.source  out_if,
  acm_cfg_if.sink    cfg_if
);

  localparam int CNT_W = $clog2(LANES + 1);

  acm_pkg::acm_mix_t              blend_mode_r;
  acm_pkg::acm_width_t            sample_width_r;
  logic [acm_pkg::MAX_CH_W-1:0]   lane_limit_r;
  logic                           select_oldest_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  acm_pkg::acm_en_t en;

  logic signed [acm_pkg::SAMPLE_W-1:0] smp1 [LANES];
  logic [CNT_W-1:0]                    cnt1;
  acm_pkg::acm_ctl_t                   ctl1;
  logic [acm_pkg::RECIP_W-1:0]         recip1;
  logic signed [acm_pkg::SAMPLE_W-1:0] quot3 [LANES];

  // register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r    <= acm_pkg::MIX_FAST;
      sample_width_r  <= acm_pkg::WIDTH_16;
      lane_limit_r    <= acm_pkg::MAX_CH_RESET;
      select_oldest_r <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        acm_pkg::REG_BLEND_MODE:    blend_mode_r    <= acm_pkg::acm_mix_t'(cfg_if.data[0]);
        acm_pkg::REG_SAMPLE_WIDTH:  sample_width_r  <= acm_pkg::acm_width_t'(cfg_if.data[0]);
        acm_pkg::REG_LANE_LIMIT:    lane_limit_r    <= cfg_if.data[acm_pkg::MAX_CH_W-1:0];
        acm_pkg::REG_SELECT_OLDEST: select_oldest_r <= cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  // pipeline flow control: a stage loads when empty or when it moves on
  always_comb begin
    rdy4   = !v4_r || out_if.ready;
    rdy3   = !v3_r || rdy4;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    en     = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};
    v1_nxt = rdy1 ? in_if.valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_if.ready  = rdy1;
  assign out_if.valid = v4_r;

  acm_select #(
    .LANES (LANES)
  ) u_select (
    .clk            (clk),
    .en             (en.s1),
    .sample_lane    (in_if.sample_lane),
    .active_mask    (in_if.active_mask),
    .last_in_buffer (in_if.last_in_buffer),
    .blend_mode     (blend_mode_r),
    .sample_width   (sample_width_r),
    .lane_limit     (lane_limit_r),
    .select_oldest  (select_oldest_r),
    .smp_r          (smp1),
    .cnt_r          (cnt1),
    .ctl_r          (ctl1)
  );

  assign recip1 = acm_pkg::recip_lookup(acm_pkg::RECIP_IDX_W'(cnt1));

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    acm_lane u_lane (
      .clk    (clk),
      .en     (en),
      .smp    (smp1[g]),
      .recip  (recip1),
      .quot_r (quot3[g])
    );
  end

  acm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk             (clk),
    .en              (en),
    .smp             (smp1),
    .cnt             (cnt1),
    .ctl             (ctl1),
    .quot            (quot3),
    .mixed_sample_r  (out_if.mixed_sample),
    .lanes_mixed_r   (out_if.lanes_mixed),
    .end_of_buffer_r (out_if.end_of_buffer)
  );

endmodule

`default_nettype wire

// ----- rtl/acm_select.sv -----
// ----------------------------------------------------------------------------
// acm_select
// Ranks the active lanes, applies the channel limit and sign extends samples.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_select #(
  parameter int LANES = acm_pkg::LANES_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [LANES-1:0][acm_pkg::SAMPLE_W-1:0] sample_lane,
  input  logic [LANES-1:0]                        active_mask,
  input  logic                                    last_in_buffer,
  input  acm_pkg::acm_mix_t                       blend_mode,
  input  acm_pkg::acm_width_t                     sample_width,
  input  logic [acm_pkg::MAX_CH_W-1:0]            lane_limit,
  input  logic                                    select_oldest,
  output logic signed [acm_pkg::SAMPLE_W-1:0]     smp_r [LANES],
  output logic [$clog2(LANES+1)-1:0]              cnt_r,
  output acm_pkg::acm_ctl_t                       ctl_r
);

  localparam int CNT_W = $clog2(LANES + 1);
  localparam int CMP_W = (CNT_W > acm_pkg::MAX_CH_W) ? CNT_W : acm_pkg::MAX_CH_W;

  logic [CNT_W-1:0]                    rank [LANES];
  logic [LANES-1:0]                    sel;
  logic [LANES-1:0]                    ahead;
  logic signed [acm_pkg::SAMPLE_W-1:0] ext [LANES];
  logic signed [acm_pkg::SAMPLE_W-1:0] smp_nxt [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      // lanes that come earlier in the selection order
      for (int j = 0; j < LANES; j++) begin
        ahead[j] = active_mask[j] && (select_oldest ? (j > i) : (j < i));
      end
      rank[i] = CNT_W'($countones(ahead));
      sel[i]  = active_mask[i] &&
                ((lane_limit == '0) || (CMP_W'(rank[i]) < CMP_W'(lane_limit)));
      if (sample_width == acm_pkg::WIDTH_16) begin
        ext[i] = $signed(sample_lane[i]);
      end else begin
        ext[i] = $signed({{(acm_pkg::SAMPLE_W-acm_pkg::NARROW_W){sample_lane[i][acm_pkg::NARROW_W-1]}},
                          sample_lane[i][acm_pkg::NARROW_W-1:0]});
      end
      smp_nxt[i] = sel[i] ? ext[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        smp_r[i] <= smp_nxt[i];
      end
      cnt_r <= CNT_W'($countones(sel));
      ctl_r <= '{mode: blend_mode, width: sample_width, last: last_in_buffer};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/acm_lane.sv -----
// ----------------------------------------------------------------------------
// acm_lane
// Per-lane truncating divide by the lane count for the fast mix path.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_lane (
  input  logic                                 clk,
  input  acm_pkg::acm_en_t                     en,
  input  logic signed [acm_pkg::SAMPLE_W-1:0]  smp,
  input  logic [acm_pkg::RECIP_W-1:0]          recip,
  output logic signed [acm_pkg::SAMPLE_W-1:0]  quot_r
);

  localparam int PROD_W = acm_pkg::SAMPLE_W + acm_pkg::RECIP_W;

  logic [acm_pkg::SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]            prod_r;
  logic                         neg_r;
  logic [acm_pkg::SAMPLE_W-1:0] q;

  // magnitude of the most negative sample still fits unsigned
  assign mag = smp[acm_pkg::SAMPLE_W-1] ? acm_pkg::SAMPLE_W'(-smp) : acm_pkg::SAMPLE_W'(smp);
  assign q   = prod_r[acm_pkg::RECIP_SHIFT +: acm_pkg::SAMPLE_W];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= PROD_W'(mag) * PROD_W'(recip);
      neg_r  <= smp[acm_pkg::SAMPLE_W-1];
    end
    if (en.s3) begin
      quot_r <= neg_r ? $signed(-q) : $signed(q);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/acm_merge.sv -----
// ----------------------------------------------------------------------------
// acm_merge
// Wide sum and divide for quality mode, lane quotient sum for fast mode,
// and the final result register.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_merge #(
  parameter int LANES = acm_pkg::LANES_DEF
) (
  input  logic                                 clk,
  input  acm_pkg::acm_en_t                     en,
  input  logic signed [acm_pkg::SAMPLE_W-1:0]  smp [LANES],
  input  logic [$clog2(LANES+1)-1:0]           cnt,
  input  acm_pkg::acm_ctl_t                    ctl,
  input  logic signed [acm_pkg::SAMPLE_W-1:0]  quot [LANES],
  output logic signed [acm_pkg::SAMPLE_W-1:0]  mixed_sample_r,
  output logic [acm_pkg::CNT_OUT_W-1:0]        lanes_mixed_r,
  output logic                                 end_of_buffer_r
);

  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int SUM_W  = acm_pkg::SAMPLE_W + $clog2(LANES);
  localparam int PROD_W = SUM_W + acm_pkg::RECIP_W;
  localparam int SW     = acm_pkg::SAMPLE_W;
  localparam int NW     = acm_pkg::NARROW_W;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum2_r;
  logic [CNT_W-1:0]         cnt2_r;
  acm_pkg::acm_ctl_t        ctl2_r;
  logic [SUM_W-1:0]         mag2;
  logic [acm_pkg::RECIP_W-1:0] recip2;

  logic [PROD_W-1:0]        qprod3_r;
  logic                     qneg3_r;
  logic [SW-1:0]            sum3_r;
  logic [CNT_W-1:0]         cnt3_r;
  acm_pkg::acm_ctl_t        ctl3_r;

  logic [SW-1:0]            fsum;
  logic [SW-1:0]            qq;
  logic [SW-1:0]            res;
  logic [SW-1:0]            res_ext;

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + SUM_W'(smp[i]);
    end
  end

  assign mag2   = sum2_r[SUM_W-1] ? SUM_W'(-sum2_r) : SUM_W'(sum2_r);
  assign recip2 = acm_pkg::recip_lookup(acm_pkg::RECIP_IDX_W'(cnt2_r));

  // fast mode wraps at the sample width, low bits are all that matter
  always_comb begin
    fsum = '0;
    for (int i = 0; i < LANES; i++) begin
      fsum = fsum + SW'(quot[i]);
    end
  end

  assign qq = qprod3_r[acm_pkg::RECIP_SHIFT +: SW];

  always_comb begin
    if (cnt3_r <= CNT_W'(1)) begin
      // zero lanes sum to zero, one lane sums to its own sample
      res = sum3_r;
    end else if (ctl3_r.mode == acm_pkg::MIX_FAST) begin
      res = fsum;
    end else begin
      res = qneg3_r ? SW'(-qq) : qq;
    end
    if (ctl3_r.width == acm_pkg::WIDTH_16) begin
      res_ext = res;
    end else begin
      res_ext = {{(SW-NW){res[NW-1]}}, res[NW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sum2_r <= sum;
      cnt2_r <= cnt;
      ctl2_r <= ctl;
    end
    if (en.s3) begin
      qprod3_r <= PROD_W'(mag2) * PROD_W'(recip2);
      qneg3_r  <= sum2_r[SUM_W-1];
      sum3_r   <= sum2_r[SW-1:0];
      cnt3_r   <= cnt2_r;
      ctl3_r   <= ctl2_r;
    end
    if (en.s4) begin
      mixed_sample_r  <= $signed(res_ext);
      lanes_mixed_r   <= acm_pkg::CNT_OUT_W'(cnt3_r);
      end_of_buffer_r <= ctl3_r.last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/acm_checker.sv -----
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks of the audio channel mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module acm_checker #(
  parameter int LANES = acm_pkg::LANES_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [acm_pkg::SAMPLE_W-1:0] out_mixed_sample,
  input logic [acm_pkg::CNT_OUT_W-1:0]       out_lanes_mixed,
  input logic                                out_end_of_buffer
);

  logic                                          out_stall;
  logic [acm_pkg::SAMPLE_W+acm_pkg::CNT_OUT_W:0] out_payload;
  logic                                          out_silent;
  logic                                          lanes_ok;

  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_mixed_sample, out_lanes_mixed, out_end_of_buffer};
  // a count of sixteen lanes wraps to zero in the 4-bit field
  assign out_silent  = out_valid && (out_lanes_mixed == '0) && (LANES < 16);
  assign lanes_ok    = (LANES > 15) || (int'(out_lanes_mixed) <= LANES);

  // a stalled transaction holds its payload
  `ACM_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled output moved")

  // reset empties the pipeline
  `ACM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

  // an empty output stage never blocks the input
  `ACM_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // a frame with no lane mixed is silent
  `ACM_ASSERT(a_silent_frame, out_silent |-> out_mixed_sample == '0, "sample with no lanes")

  // never more lanes than the block has
  `ACM_ASSERT(a_lane_count, out_valid |-> lanes_ok, "lane count out of range")

endmodule

bind audio_channel_mixer acm_checker #(
  .LANES (LANES)
) u_acm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_mixed_sample  (out_if.mixed_sample),
  .out_lanes_mixed   (out_if.lanes_mixed),
  .out_end_of_buffer (out_if.end_of_buffer)
);

`default_nettype wire

// ----- tb/acm_mix_checker.sv -----
// ----------------------------------------------------------------------------
// acm_mix_checker
// Watches the frame, result and register channels of the mixer, keeps its
// own copy of the settings, predicts each mixed sample and compares it with
// what comes out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acm_mix_checker #(
  parameter int LANES = acm_pkg::LANES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  acm_in_if    in_if,
  acm_out_if   out_if,
  acm_cfg_if   cfg_if,
  output int   mismatch_count,
  output int   pending,
  output int   results_checked
);

  typedef struct packed {
    logic signed [acm_pkg::SAMPLE_W-1:0] sample;
    logic [acm_pkg::CNT_OUT_W-1:0]       lanes;
    logic                                eob;
  } mix_result_t;

  acm_pkg::acm_mix_t            mode_q;
  acm_pkg::acm_width_t          width_q;
  logic [acm_pkg::MAX_CH_W-1:0] max_ch_q;
  logic                         oldest_q;

  mix_result_t expected_mixes[$];
  int          err_cnt = 0;
  int          n_checked = 0;

  function automatic mix_result_t predict_mix(
    input logic [LANES-1:0][acm_pkg::SAMPLE_W-1:0] samples,
    input logic [LANES-1:0]                        mask,
    input logic                                    last
  );
    int          picked [LANES];
    int          count;
    int          lane;
    int          acc;
    int          k;
    logic [31:0] wide;
    mix_result_t r;
    count = 0;
    acc = 0;
    for (k = 0; k < LANES; k++) begin
      lane = oldest_q ? LANES - 1 - k : k;
      // a limit of zero means every active lane takes part
      if (mask[lane] && (max_ch_q == '0 || count < int'(max_ch_q))) begin
        if (width_q == acm_pkg::WIDTH_8) begin
          picked[count] = int'($signed(samples[lane][acm_pkg::NARROW_W-1:0]));
        end else begin
          picked[count] = int'($signed(samples[lane]));
        end
        count++;
      end
    end
    if (count == 1) begin
      acc = picked[0];
    end else if (count > 1) begin
      if (mode_q == acm_pkg::MIX_FAST) begin
        for (k = 0; k < count; k++) acc += picked[k] / count;
      end else begin
        for (k = 0; k < count; k++) acc += picked[k];
        acc = acc / count;
      end
    end
    wide = acc;
    if (width_q == acm_pkg::WIDTH_8) begin
      r.sample = {{(acm_pkg::SAMPLE_W-acm_pkg::NARROW_W){wide[acm_pkg::NARROW_W-1]}},
                  wide[acm_pkg::NARROW_W-1:0]};
    end else begin
      r.sample = wide[acm_pkg::SAMPLE_W-1:0];
    end
    r.lanes = acm_pkg::CNT_OUT_W'(count);
    r.eob = last;
    return r;
  endfunction

  always @(posedge clk) begin
    mix_result_t want;
    if (!rst_n) begin
      mode_q   = acm_pkg::MIX_FAST;
      width_q  = acm_pkg::WIDTH_16;
      max_ch_q = acm_pkg::MAX_CH_RESET;
      oldest_q = 1'b0;
      expected_mixes.delete();
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_mixes.insert(expected_mixes.size(),
                              predict_mix(in_if.sample_lane, in_if.active_mask,
                                          in_if.last_in_buffer));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_mixes.size() == 0) begin
          $display("%0t unexpected result transaction: expected none actual sample %0d",
                   $time, out_if.mixed_sample);
          err_cnt++;
        end else begin
          want = expected_mixes[0];
          expected_mixes.delete(0);
          n_checked++;
          if (out_if.mixed_sample !== want.sample) begin
            $display("%0t mixed_sample mismatch: expected %0d actual %0d",
                     $time, want.sample, out_if.mixed_sample);
            err_cnt++;
          end
          if (out_if.lanes_mixed !== want.lanes) begin
            $display("%0t lanes_mixed mismatch: expected %0d actual %0d",
                     $time, want.lanes, out_if.lanes_mixed);
            err_cnt++;
          end
          if (out_if.end_of_buffer !== want.eob) begin
            $display("%0t end_of_buffer mismatch: expected %0b actual %0b",
                     $time, want.eob, out_if.end_of_buffer);
            err_cnt++;
          end
        end
      end
      // settings change after this edge's frame has been predicted
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          acm_pkg::REG_BLEND_MODE:    mode_q   = acm_pkg::acm_mix_t'(cfg_if.data[0]);
          acm_pkg::REG_SAMPLE_WIDTH:  width_q  = acm_pkg::acm_width_t'(cfg_if.data[0]);
          acm_pkg::REG_LANE_LIMIT:    max_ch_q = cfg_if.data[acm_pkg::MAX_CH_W-1:0];
          acm_pkg::REG_SELECT_OLDEST: oldest_q = cfg_if.data[0];
          default: ;
        endcase
      end
    end
    pending         <= expected_mixes.size();
    mismatch_count  <= err_cnt;
    results_checked <= n_checked;
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives frames and register writes into the audio channel mixer with random
// idle and stall patterns, including one long output hold-off, and reports
// the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int LANES          = acm_pkg::LANES_DEF;
  localparam int MAX_IDLE       = 17;
  localparam int RAND_PHASES    = 16;
  localparam int RAND_PER_PHASE = 80;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [acm_pkg::CFG_IDX_W-1:0] REG_SPARE =
    acm_pkg::CFG_IDX_W'(acm_pkg::REG_SELECT_OLDEST) + 1'b1;

  typedef struct packed {
    logic [LANES-1:0][acm_pkg::SAMPLE_W-1:0] lanes;
    logic [LANES-1:0]                        mask;
    logic                                    last;
  } frame_t;

  logic clk;
  logic rst_n;

  acm_in_if #(.LANES(LANES)) in_ch ();
  acm_out_if                 out_ch ();
  acm_cfg_if                 cfg_ch ();

  int mismatch_count;
  int pending;
  int results_checked;

  int tx_gap_max   = MAX_IDLE;
  int rx_stall_max = MAX_IDLE;
  int hold_req     = 0;
  int n_frames     = 0;
  int n_settings   = 0;

  audio_channel_mixer #(.LANES(LANES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  acm_mix_checker #(.LANES(LANES)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_if           (in_ch),
    .out_if          (out_ch),
    .cfg_if          (cfg_ch),
    .mismatch_count  (mismatch_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic frame_t uniform_frame(input logic [acm_pkg::SAMPLE_W-1:0] v,
                                           input logic [LANES-1:0] mask,
                                           input logic last);
    frame_t f;
    int     k;
    for (k = 0; k < LANES; k++) f.lanes[k] = v;
    f.mask = mask;
    f.last = last;
    return f;
  endfunction

  // even lanes carry a, odd lanes b
  function automatic frame_t alt_frame(input logic [acm_pkg::SAMPLE_W-1:0] a,
                                       input logic [acm_pkg::SAMPLE_W-1:0] b,
                                       input logic [LANES-1:0] mask,
                                       input logic last);
    frame_t f;
    int     k;
    f = uniform_frame(a, mask, last);
    for (k = 1; k < LANES; k += 2) f.lanes[k] = b;
    return f;
  endfunction

  function automatic frame_t rand_frame();
    frame_t                       f;
    int                           style;
    int                           k;
    int                           tiny;
    logic [acm_pkg::SAMPLE_W-1:0] v;
    style = $urandom_range(7, 0);
    v = acm_pkg::SAMPLE_W'($urandom);
    for (k = 0; k < LANES; k++) begin
      case (style)
        0, 1, 2: f.lanes[k] = acm_pkg::SAMPLE_W'($urandom);
        3: begin
          case ($urandom_range(5, 0))
            0:       f.lanes[k] = 16'h7FFF;
            1:       f.lanes[k] = 16'h8000;
            2:       f.lanes[k] = 16'hFFFF;
            3:       f.lanes[k] = 16'h0000;
            4:       f.lanes[k] = {8'($urandom), 8'h7F};
            default: f.lanes[k] = {8'($urandom), 8'h80};
          endcase
        end
        4: begin
          // small magnitudes make truncation toward zero visible
          tiny = int'($urandom_range(40, 0)) - 20;
          f.lanes[k] = acm_pkg::SAMPLE_W'(tiny);
        end
        5:       f.lanes[k] = v;
        6:       f.lanes[k] = {1'b1, 15'($urandom)};
        default: f.lanes[k] = {1'b0, 15'($urandom)};
      endcase
    end
    case ($urandom_range(5, 0))
      0:       f.mask = '0;
      1:       f.mask = '1;
      2:       f.mask = LANES'(1) << $urandom_range(LANES - 1, 0);
      default: f.mask = LANES'($urandom);
    endcase
    f.last = ($urandom_range(7, 0) == 0);
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_lane    <= f.lanes;
    in_ch.active_mask    <= f.mask;
    in_ch.last_in_buffer <= f.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_frames++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [acm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acm_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one-bit registers get junk in the unused data bits
  task automatic set_config(input acm_pkg::acm_mix_t mode, input acm_pkg::acm_width_t width,
                            input logic [acm_pkg::MAX_CH_W-1:0] max_ch, input logic oldest);
    logic [acm_pkg::CFG_DATA_W-2:0] junk;
    wait_drained();
    junk = (acm_pkg::CFG_DATA_W - 1)'($urandom);
    write_reg(acm_pkg::REG_BLEND_MODE, {junk, mode});
    junk = (acm_pkg::CFG_DATA_W - 1)'($urandom);
    write_reg(acm_pkg::REG_SAMPLE_WIDTH, {junk, width});
    write_reg(acm_pkg::REG_LANE_LIMIT, acm_pkg::CFG_DATA_W'(max_ch));
    junk = (acm_pkg::CFG_DATA_W - 1)'($urandom);
    write_reg(acm_pkg::REG_SELECT_OLDEST, {junk, oldest});
    n_settings++;
  endtask

  // result side: random stall per transaction, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = $urandom_range(rx_stall_max, 0);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t timeout: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int                           phase;
    logic [acm_pkg::MAX_CH_W-1:0] max_ch;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_lane    <= '0;
    in_ch.active_mask    <= '0;
    in_ch.last_in_buffer <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings out of reset: fast, 16 bit, four lanes, youngest first
    send_frame(uniform_frame(16'h7FFF, 8'h00, 1'b0));
    send_frame(uniform_frame(16'h7FFF, 8'h01, 1'b0));
    send_frame(uniform_frame(16'h8000, 8'h80, 1'b0));
    send_frame(uniform_frame(16'h7FFF, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h8000, 8'hFF, 1'b1));
    send_frame(uniform_frame(16'hFFFF, 8'h07, 1'b0));

    // limit equal to the lane count
    set_config(acm_pkg::MIX_QUALITY, acm_pkg::WIDTH_16, acm_pkg::MAX_CH_W'(LANES), 1'b1);
    send_frame(uniform_frame(16'h7FFF, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h8000, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'hFFFF, 8'h07, 1'b1));
    send_frame(alt_frame(16'h7FFF, 16'h8000, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h0005, 8'h7E, 1'b0));

    // no limit at all, narrow samples with junk in the upper byte
    set_config(acm_pkg::MIX_FAST, acm_pkg::WIDTH_8, '0, 1'b0);
    // unmapped index, settings must stay as they are
    write_reg(REG_SPARE, '1);
    send_frame(uniform_frame(16'hAB7F, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h1280, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'hFF7F, 8'h03, 1'b0));
    send_frame(alt_frame(16'h5A7F, 16'hC380, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h00FF, 8'h01, 1'b1));

    // limit above the lane count
    set_config(acm_pkg::MIX_QUALITY, acm_pkg::WIDTH_8, '1, 1'b1);
    send_frame(uniform_frame(16'h007F, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h0080, 8'hFF, 1'b0));
    send_frame(uniform_frame(16'h00FF, 8'h07, 1'b0));
    send_frame(alt_frame(16'hEE7F, 16'h3380, 8'hF0, 1'b1));

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       max_ch = acm_pkg::MAX_CH_W'(1);
        1:       max_ch = acm_pkg::MAX_CH_W'(LANES);
        2:       max_ch = '0;
        3:       max_ch = '1;
        default: begin
          if ($urandom_range(3, 0) == 0) max_ch = acm_pkg::MAX_CH_W'($urandom);
          else max_ch = acm_pkg::MAX_CH_W'($urandom_range(LANES, 1));
        end
      endcase
      set_config(acm_pkg::acm_mix_t'($urandom_range(1, 0)),
                 acm_pkg::acm_width_t'($urandom_range(1, 0)),
                 max_ch, 1'($urandom_range(1, 0)));
      tx_gap_max   = (phase % 4 == 1) ? 0 : MAX_IDLE;
      rx_stall_max = (phase % 4 == 1) ? 0 : MAX_IDLE;
      if (phase == PRESSURE_PHASE) begin
        // back-to-back frames against a stopped output fill the pipeline
        tx_gap_max = 0;
        hold_req = HOLD_CYCLES;
      end
      repeat (RAND_PER_PHASE) send_frame(rand_frame());
    end

    wait_drained();
    $display("run covered %0d frames over %0d register settings, both mix modes at 8 and 16 bits",
             n_frames, n_settings);
    $display("%0d mixed samples compared; output held off once for %0d cycles",
             results_checked, HOLD_CYCLES);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
